### rtl/mse_pkg.sv
// mse_pkg: shared types and constants of the instruction execute block.
// Holds opcode and function codes, status codes, state and command types.
// No dependencies.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int INSTR_W  = 32;
    localparam int LINE_W   = 10;
    localparam int STATUS_W = 3;
    localparam int RNUM_W   = 5;
    localparam int PKIND_W  = 2;
    localparam int SWORD_W  = 10;
    localparam int OUT_W    = 96;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_EXIT    = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_SLT     = 6'd42;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_UNKNOWN  = 3'd1;
    localparam logic [2:0] STS_RANGE    = 3'd2;
    localparam logic [2:0] STS_MISALIGN = 3'd3;
    localparam logic [2:0] STS_OVERFLOW = 3'd4;
    localparam logic [2:0] STS_EXIT     = 3'd5;
    localparam logic [2:0] STS_SYSCALL  = 3'd6;
    localparam logic [2:0] STS_DIVZERO  = 3'd7;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_INT  = 2'd1;
    localparam logic [1:0] PK_CHAR = 2'd2;

    localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;
    localparam logic [4:0] REG_RA = 5'd31;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_MIDX,
        ST_WB
    } state_t;

    typedef enum logic [2:0] {
        CLS_SIMPLE,
        CLS_MULT,
        CLS_DIV,
        CLS_LOAD,
        CLS_MEMMOD
    } cls_t;

    typedef struct packed {
        logic capture;
        logic mul_load;
        logic div_start;
        logic div_mod;
        logic mem_rd;
        logic clear;
        logic commit;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic is_load;
        logic div_busy;
        logic out_free;
        logic clear_last;
    } stat_t;

endpackage

### rtl/mse_ctrl.sv
// mse_ctrl: sequencer of the execute block.
// Steps each instruction through capture, execute, long operations and write-back.
// Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  mse_pkg::stat_t stat,
    output logic           s_tready,
    output mse_pkg::cmd_t  cmd
);
    import mse_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.cls)
                    CLS_SIMPLE:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.commit = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_WB;
                        end
                    end
                    CLS_MULT:
                    begin
                        cmd.mul_load = 1'b1;
                        state_next   = ST_WB;
                    end
                    CLS_DIV:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    CLS_LOAD:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = ST_WB;
                    end
                    CLS_MEMMOD:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_mod   = 1'b1;
                        state_next    = ST_MIDX;
                    end
                    default:
                    begin
                        state_next = ST_WB;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_WB;
                end
            end
            ST_MIDX:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mem_rd = stat.is_load;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mse_dpath.sv
// mse_dpath: datapath of the execute block.
// Holds line counter, register file, HI/LO, data memory, multiplier, divider
// and the result register. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_dpath #(
    parameter int PROG_LINES = 1024,
    parameter int DATA_WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mse_pkg::cmd_t                 cmd,
    output mse_pkg::stat_t                stat,
    input  logic [mse_pkg::INSTR_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mse_pkg::OUT_W-1:0]     m_tdata
);
    import mse_pkg::*;

    localparam int PC_W = (PROG_LINES > 1) ? $clog2(PROG_LINES) : 1;
    localparam int DA_W = $clog2(DATA_WORDS);
    localparam bit DW_POW2 = (DATA_WORDS == (1 << DA_W));
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LINES - 1);
    localparam logic [DA_W-1:0] CLR_LAST = DA_W'(DATA_WORDS - 1);
    localparam logic [26:0] MOD_RECIP = 27'((64'd1 << 30) / DATA_WORDS);
    localparam logic [16:0] MOD_D = 17'(DATA_WORDS);

    logic [31:0]     ir_reg;
    logic [PC_W-1:0] pc_reg;
    logic [31:0]     hi_reg;
    logic [31:0]     lo_reg;
    logic [31:0]     rf_valid_reg;
    logic [31:0]     rf_mem [32];
    logic [31:0]     rda_reg;
    logic [31:0]     rdb_reg;
    logic            va_reg;
    logic            vb_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]     dmem [DATA_WORDS];
    logic [31:0]     dm_rd_reg;
    logic [DA_W-1:0] clr_reg;
    logic            busy_reg;
    logic [4:0]      cnt_reg;
    logic [31:0]     quo_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     dvsr_reg;
    logic [29:0]     mx_reg;
    logic [56:0]     mprod_reg;
    logic [29:0]     mqd_reg;
    logic [1:0]      mcnt_reg;
    logic            m_tvalid_reg;
    logic [LINE_W-1:0]   o_line_reg;
    logic [STATUS_W-1:0] o_status_reg;
    logic                o_wr_reg;
    logic [RNUM_W-1:0]   o_wnum_reg;
    logic [31:0]         o_wval_reg;
    logic [PKIND_W-1:0]  o_pkind_reg;
    logic [31:0]         o_pval_reg;
    logic                o_sdone_reg;
    logic [SWORD_W-1:0]  o_sword_reg;

    logic        s_sys;
    logic [4:0]  ra_addr;
    logic [4:0]  rb_addr;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] simm;
    logic [25:0] tgt;
    logic [31:0] vs;
    logic [31:0] vt;
    logic        is_load;
    logic        is_store;
    logic [31:0] maddr;
    logic [DA_W-1:0] idx;
    logic [31:0] dvd_in;
    logic [31:0] dvs_in;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        div_go;
    logic        mod_go;
    logic        mod_busy;
    logic [43:0] mqd_full;
    logic [29:0] mrem;
    logic [29:0] mfix;
    logic        dm_we;
    logic [DA_W-1:0] dm_wa;
    logic [31:0] dm_wd;

    logic [PC_W-1:0] pc_seq;
    logic [PC_W-1:0] r_next;
    logic [2:0]  r_status;
    logic        r_wr;
    logic [4:0]  r_wnum;
    logic [31:0] r_wval;
    logic [1:0]  r_pkind;
    logic [31:0] r_pval;
    logic        r_sdone;
    logic        r_hilo_we;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic        br;
    logic        cond;
    logic [32:0] sum33;
    logic [32:0] dif33;
    logic [32:0] addi33;
    logic [33:0] bt34;
    logic [31:0] q_fix;
    logic [31:0] r_fix;

    assign s_sys   = (s_tdata[31:26] == OP_SPECIAL) && (s_tdata[5:0] == FN_SYSCALL);
    assign ra_addr = s_sys ? REG_V0 : s_tdata[25:21];
    assign rb_addr = s_sys ? REG_A0 : s_tdata[20:16];

    assign op   = ir_reg[31:26];
    assign fn   = ir_reg[5:0];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sa   = ir_reg[10:6];
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign tgt  = ir_reg[25:0];
    assign vs   = va_reg ? rda_reg : '0;
    assign vt   = vb_reg ? rdb_reg : '0;

    assign is_load  = (op == OP_LW);
    assign is_store = (op == OP_SW);
    assign maddr    = vs + simm;
    assign idx      = DW_POW2 ? maddr[2 +: DA_W] : mfix[DA_W-1:0];

    always_comb
    begin
        if ((op == OP_SPECIAL) && (fn == FN_MULT))
        begin
            stat.cls = CLS_MULT;
        end
        else if ((op == OP_SPECIAL) && (fn == FN_DIV) && (vt != '0))
        begin
            stat.cls = CLS_DIV;
        end
        else if ((is_load || is_store) && !DW_POW2)
        begin
            stat.cls = CLS_MEMMOD;
        end
        else if (is_load)
        begin
            stat.cls = CLS_LOAD;
        end
        else
        begin
            stat.cls = CLS_SIMPLE;
        end
    end

    assign stat.is_load    = is_load;
    assign stat.div_busy   = busy_reg || mod_busy;
    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign stat.clear_last = (clr_reg == CLR_LAST);

    // register file: two registered read ports, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ir_reg  <= s_tdata;
            rda_reg <= rf_mem[ra_addr];
            rdb_reg <= rf_mem[rb_addr];
            va_reg  <= rf_valid_reg[ra_addr];
            vb_reg  <= rf_valid_reg[rb_addr];
        end
        if (cmd.commit && r_wr)
        begin
            rf_mem[r_wnum] <= r_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            pc_reg       <= '0;
            hi_reg       <= '0;
            lo_reg       <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                pc_reg <= r_next;
                if (r_wr)
                begin
                    rf_valid_reg[r_wnum] <= 1'b1;
                end
                if (r_hilo_we)
                begin
                    hi_reg <= r_hi;
                    lo_reg <= r_lo;
                end
            end
            if (cmd.clear && !stat.clear_last)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= $signed(vs) * $signed(vt);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_go  = cmd.div_start && !cmd.div_mod;
    assign dvd_in  = vs[31] ? -vs : vs;
    assign dvs_in  = vt[31] ? -vt : vt;
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (div_go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_go)
        begin
            quo_reg  <= dvd_in;
            rem_reg  <= '0;
            dvsr_reg <= dvs_in;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
            quo_reg <= {quo_reg[30:0], !diff[32]};
        end
    end

    // word index modulo DATA_WORDS: reciprocal multiply, back-multiply, one correction
    assign mod_go   = cmd.div_start && cmd.div_mod;
    assign mod_busy = (mcnt_reg != 2'd0);
    assign mqd_full = mprod_reg[56:30] * MOD_D;
    assign mrem     = mx_reg - mqd_reg;
    assign mfix     = (mrem >= 30'(DATA_WORDS)) ? mrem - 30'(DATA_WORDS) : mrem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
        end
        else if (mod_go)
        begin
            mcnt_reg <= 2'd2;
        end
        else if (mod_busy)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_go)
        begin
            mx_reg <= maddr[31:2];
        end
        mprod_reg <= mx_reg * MOD_RECIP;
        mqd_reg   <= mqd_full[29:0];
    end

    // data memory: clearing pass after reset, store at commit
    assign dm_we = cmd.clear || (cmd.commit && is_store);
    assign dm_wa = cmd.clear ? clr_reg : idx;
    assign dm_wd = cmd.clear ? '0 : vt;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_wa] <= dm_wd;
        end
        if (cmd.mem_rd)
        begin
            dm_rd_reg <= dmem[idx];
        end
    end

    assign pc_seq = (pc_reg == PC_LAST) ? '0 : pc_reg + 1'b1;
    assign sum33  = {vs[31], vs} + {vt[31], vt};
    assign dif33  = {vs[31], vs} - {vt[31], vt};
    assign addi33 = {vs[31], vs} + {simm[31], simm};
    assign bt34   = 34'(pc_reg) + 34'd1 + {{18{ir_reg[15]}}, ir_reg[15:0]};
    assign q_fix  = (vs[31] ^ vt[31]) ? -quo_reg : quo_reg;
    assign r_fix  = vs[31] ? -rem_reg : rem_reg;

    always_comb
    begin
        r_next    = pc_seq;
        r_status  = STS_OK;
        r_wr      = 1'b0;
        r_wnum    = '0;
        r_wval    = '0;
        r_pkind   = PK_NONE;
        r_pval    = '0;
        r_sdone   = 1'b0;
        r_hilo_we = 1'b0;
        r_hi      = hi_reg;
        r_lo      = lo_reg;
        br        = 1'b0;
        cond      = 1'b0;
        if (op == OP_SPECIAL)
        begin
            case (fn)
                FN_ADD:
                begin
                    if (sum33[32] != sum33[31])
                    begin
                        r_status = STS_OVERFLOW;
                    end
                    else
                    begin
                        r_wr   = 1'b1;
                        r_wnum = rd;
                        r_wval = sum33[31:0];
                    end
                end
                FN_SUB:
                begin
                    if (dif33[32] != dif33[31])
                    begin
                        r_status = STS_OVERFLOW;
                    end
                    else
                    begin
                        r_wr   = 1'b1;
                        r_wnum = rd;
                        r_wval = dif33[31:0];
                    end
                end
                FN_AND:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = vs & vt;
                end
                FN_OR:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = vs | vt;
                end
                FN_XOR:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = vs ^ vt;
                end
                FN_SLT:
                begin
                    r_wr   = 1'b1;
                    r_wnum = rd;
                    r_wval = {31'd0, ($signed(vs) < $signed(vt))};
                end
                FN_SLL:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = vt << sa;
                end
                FN_SRL:
                begin
                    r_wr   = 1'b1;
                    r_wnum = rd;
                    if (ir_reg[21])
                    begin
                        r_wval = (vt >> sa) | (vt << (6'd32 - {1'b0, sa}));
                    end
                    else
                    begin
                        r_wval = vt >> sa;
                    end
                end
                FN_MFHI:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = hi_reg;
                end
                FN_MFLO:
                begin
                    r_wr = 1'b1; r_wnum = rd; r_wval = lo_reg;
                end
                FN_MULT:
                begin
                    r_hilo_we = 1'b1;
                    r_hi      = prod_reg[63:32];
                    r_lo      = prod_reg[31:0];
                end
                FN_DIV:
                begin
                    if (vt == '0)
                    begin
                        r_status = STS_DIVZERO;
                    end
                    else
                    begin
                        r_hilo_we = 1'b1;
                        r_hi      = r_fix;
                        r_lo      = q_fix;
                    end
                end
                FN_JR:
                begin
                    if (vs[1:0] != 2'b00)
                    begin
                        r_status = STS_MISALIGN;
                    end
                    else if ({2'b00, vs[31:2]} >= 32'(PROG_LINES))
                    begin
                        r_status = STS_RANGE;
                    end
                    else
                    begin
                        r_next = vs[2 +: PC_W];
                    end
                end
                FN_SYSCALL:
                begin
                    if (vs == SYS_PRINT_INT)
                    begin
                        r_pkind = PK_INT;
                        r_pval  = vt;
                    end
                    else if (vs == SYS_PRINT_CHAR)
                    begin
                        r_pkind = PK_CHAR;
                        r_pval  = vt;
                    end
                    else
                    begin
                        r_status = STS_SYSCALL;
                    end
                end
                default:
                begin
                    r_status = STS_UNKNOWN;
                end
            endcase
        end
        else
        begin
            case (op)
                OP_ADDI:
                begin
                    if (addi33[32] != addi33[31])
                    begin
                        r_status = STS_OVERFLOW;
                    end
                    else
                    begin
                        r_wr   = 1'b1;
                        r_wnum = rt;
                        r_wval = addi33[31:0];
                    end
                end
                OP_BEQ:
                begin
                    br = 1'b1; cond = (vs == vt);
                end
                OP_BNE:
                begin
                    br = 1'b1; cond = (vs != vt);
                end
                OP_BGTZ:
                begin
                    br = 1'b1; cond = !vs[31] && (vs != '0);
                end
                OP_BLEZ:
                begin
                    br = 1'b1; cond = vs[31] || (vs == '0);
                end
                OP_J,
                OP_JAL:
                begin
                    if ({6'd0, tgt} >= 32'(PROG_LINES))
                    begin
                        r_status = STS_RANGE;
                    end
                    else
                    begin
                        if (op == OP_JAL)
                        begin
                            r_wr   = 1'b1;
                            r_wnum = REG_RA;
                            r_wval = (32'(pc_reg) + 32'd2) << 2;
                        end
                        r_next = tgt[PC_W-1:0];
                    end
                end
                OP_LUI:
                begin
                    r_wr = 1'b1; r_wnum = rt; r_wval = {ir_reg[15:0], 16'd0};
                end
                OP_LW:
                begin
                    r_wr = 1'b1; r_wnum = rt; r_wval = dm_rd_reg;
                end
                OP_SW:
                begin
                    r_sdone = 1'b1;
                end
                OP_EXIT:
                begin
                    r_status = STS_EXIT;
                    r_next   = pc_reg;
                end
                default:
                begin
                    r_status = STS_UNKNOWN;
                end
            endcase
        end
        if (br && cond)
        begin
            if (bt34[33] || (bt34[32:0] >= 33'(PROG_LINES)))
            begin
                r_status = STS_RANGE;
            end
            else
            begin
                r_next = bt34[PC_W-1:0];
            end
        end
        if (!r_wr || (r_wnum == '0))
        begin
            r_wr   = 1'b0;
            r_wnum = '0;
            r_wval = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_line_reg   <= LINE_W'(r_next);
            o_status_reg <= r_status;
            o_wr_reg     <= r_wr;
            o_wnum_reg   <= r_wnum;
            o_wval_reg   <= r_wval;
            o_pkind_reg  <= r_pkind;
            o_pval_reg   <= r_pval;
            o_sdone_reg  <= r_sdone;
            o_sword_reg  <= r_sdone ? SWORD_W'(idx) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_sword_reg, o_sdone_reg, o_pval_reg, o_pkind_reg, o_wval_reg,
                       o_wnum_reg, o_wr_reg, o_status_reg, o_line_reg};

endmodule

### rtl/mips_subset_execute.sv
// mips_subset_execute: top level of the instruction execute block.
// Joins the sequencer mse_ctrl and the datapath mse_dpath. Depends on mse_pkg.
`timescale 1ns / 1ps

// Takes one instruction word per input beat and returns one result beat with
// the next line, a status code, the register write, the print request and the
// store. Most instructions go from accept to result through the execute state;
// LW and MULT also pass the memory read port or the multiplier register, and a
// DIV by a nonzero divisor waits for the divider, one quotient bit per cycle.
// When DATA_WORDS is not a power of two, LW and SW wait while the word index is
// reduced by a reciprocal multiply. After reset the block clears its data
// memory, one word a cycle, and accepts no instruction until then. A finished
// result waits in the output register while the next instruction is accepted.
module mips_subset_execute #(
    parameter int PROG_LINES = 1024,
    parameter int DATA_WORDS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mse_pkg::INSTR_W-1:0] s_tdata,  // instruction
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // next_line, status, reg_written, reg_number, reg_value, print_kind,
    // print_value, store_done, store_word
    output logic [mse_pkg::OUT_W-1:0]   m_tdata
);
    import mse_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mse_dpath #(
        .PROG_LINES (PROG_LINES),
        .DATA_WORDS (DATA_WORDS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
